@@ hw/rtl/pbeq_pkg.sv @@
// Shared types, constants and microcode ROM for the parallel biquad EQ bank.
// Depends on nothing; imported by parallel_biquad_eq_bank, pbeq_checker and tb_top.
package pbeq_pkg;

	// Fixed field widths
	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int YHIST_W   = 32;
	localparam int COEF_FRAC = COEF_W - 4;
	localparam int OP_W      = (YHIST_W > SAMPLE_W) ? YHIST_W : SAMPLE_W;
	localparam int PROD_W    = COEF_W + OP_W;
	localparam int ACC_W     = PROD_W + 3;
	localparam int RND_W     = ACC_W - COEF_FRAC;

	localparam int DEF_BANDS      = 8;
	localparam int DEF_CHANNELS   = 2;
	localparam int COEFS_PER_BAND = 5;

	localparam int ACT_W  = 4;
	localparam int NB_W   = 5;
	localparam int BIDX_W = 3;
	localparam int CSEL_W = 3;

	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(8);
	localparam logic [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (COEF_FRAC - 1);

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

	typedef logic [CSEL_W-1:0] csel_t;
	localparam csel_t CS_B0 = 3'd0;
	localparam csel_t CS_B1 = 3'd1;
	localparam csel_t CS_B2 = 3'd2;
	localparam csel_t CS_A1 = 3'd3;
	localparam csel_t CS_A2 = 3'd4;

	typedef struct packed {
		logic                        cmd;
		logic signed [SAMPLE_W-1:0]  sample_in;
		logic                        channel;
		logic                        frame_end;
		logic [BIDX_W-1:0]           band_index;
		csel_t                       coeff_select;
		logic signed [COEF_W-1:0]    coeff_value;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       channel_out;
		logic                       frame_end_out;
		logic                       clipped;
	} result_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x1;
		logic signed [SAMPLE_W-1:0] x2;
		logic signed [YHIST_W-1:0]  y1;
		logic signed [YHIST_W-1:0]  y2;
	} hist_row_t;

	// Microcode step addresses
	typedef logic [3:0] upc_t;
	localparam upc_t U_START = 4'd0;
	localparam upc_t U_K0    = 4'd1;
	localparam upc_t U_K1    = 4'd2;
	localparam upc_t U_K2    = 4'd3;
	localparam upc_t U_K3    = 4'd4;
	localparam upc_t U_K4    = 4'd5;
	localparam upc_t U_D0    = 4'd6;
	localparam upc_t U_D1    = 4'd7;
	localparam upc_t U_D2    = 4'd8;
	localparam upc_t U_D3    = 4'd9;
	localparam upc_t U_FIN   = 4'd10;

	typedef enum logic [2:0] {
		C_NONE,
		C_ALWAYS,
		C_NB_ZERO,
		C_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic  coef_rd;
		logic  hist_rd;
		csel_t csel;
		logic  last;
		logic  clr;
		logic  done;
		cond_t cond;
		upc_t  target;
	} ucw_t;

	// Control tag that follows a product down the MAC pipe
	typedef struct packed {
		logic  valid;
		csel_t csel;
		logic  last;
	} ctl_t;

	function automatic ucw_t ucode(input upc_t pc);
		ucw_t w;
		w.coef_rd = 1'b0;
		w.hist_rd = 1'b0;
		w.csel    = CS_B0;
		w.last    = 1'b0;
		w.clr     = 1'b0;
		w.done    = 1'b0;
		w.cond    = C_NONE;
		w.target  = U_START;
		case (pc)
			U_START: begin
				w.clr    = 1'b1;
				w.cond   = C_NB_ZERO;
				w.target = U_FIN;
			end
			U_K0: begin
				w.coef_rd = 1'b1;
				w.hist_rd = 1'b1;
				w.csel    = CS_B0;
			end
			U_K1: begin
				w.coef_rd = 1'b1;
				w.csel    = CS_B1;
			end
			U_K2: begin
				w.coef_rd = 1'b1;
				w.csel    = CS_B2;
			end
			U_K3: begin
				w.coef_rd = 1'b1;
				w.csel    = CS_A1;
			end
			U_K4: begin
				w.coef_rd = 1'b1;
				w.csel    = CS_A2;
				w.last    = 1'b1;
				w.cond    = C_MORE;
				w.target  = U_K0;
			end
			U_D0, U_D1, U_D2, U_D3: begin
				w.cond = C_NONE;
			end
			U_FIN: begin
				w.done   = 1'b1;
				w.cond   = C_OUT_BUSY;
				w.target = U_FIN;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = U_FIN;
			end
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/parallel_biquad_eq_bank.sv @@
// Parallel peaking-biquad equalizer bank: microcoded sequencer around one shared MAC.
// Depends on pbeq_pkg (types, widths, microcode ROM).
//
//   port group     dir  handshake             word
//   item_*         in   item_valid/item_stall  item_t: sample or coefficient write
//   result_*       out  result_valid/stall     result_t: equalized sample
//   cfg_*          in   cfg_we                 active_bands (4 bits)
//
// Once a sample word is taken, no other word is taken until its final mix is done.
// nb is min(active_bands, BANDS); with no band active the sequencer goes straight to
// the final mix. The single MAC, one product per cycle, sets the pace: five products
// per band, then a pipe drain (steps D0..D3) before the final mix.
// A coefficient write word is taken without starting the sequencer and produces no result.
// Reset clears control and the valid bits of both stores; an entry never
// written reads as zero, so there is no clearing pass.
// A finished result waits in the output register while the next word is taken;
// if it is still stalled when the next one finishes, the final step holds until it drains.

module parallel_biquad_eq_bank import pbeq_pkg::*; #(
	parameter int BANDS    = DEF_BANDS,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              cfg_we,
	input  logic [ACT_W-1:0]  cfg_wdata
);

	localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int CDEPTH  = BANDS * COEFS_PER_BAND;
	localparam int CADDR_W = $clog2(CDEPTH);
	localparam int HDEPTH  = CHANNELS * BANDS;
	localparam int HADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
	localparam int BSUM_W  = YHIST_W + $clog2(BANDS) + 1;
	localparam int TOT_W   = BSUM_W + 1;

	// Saturation bounds for band outputs and the final sample
	localparam logic signed [RND_W-1:0] Y_HI =
		{{(RND_W - YHIST_W + 1){1'b0}}, {(YHIST_W - 1){1'b1}}};
	localparam logic signed [RND_W-1:0] Y_LO =
		{{(RND_W - YHIST_W + 1){1'b1}}, {(YHIST_W - 1){1'b0}}};
	localparam logic signed [TOT_W-1:0] S_HI =
		{{(TOT_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [TOT_W-1:0] S_LO =
		{{(TOT_W - SAMPLE_W + 1){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

	// ---------------------------------------------------------------
	// Sequencer state
	// ---------------------------------------------------------------
	logic              run_q;
	upc_t              pc_q;
	logic [BAND_W-1:0] band_q;
	logic [ACT_W-1:0]  active_bands_q;

	logic              run_d;
	upc_t              pc_d;
	logic [BAND_W-1:0] band_d;

	ucw_t              ucw;
	logic              cond_true;
	logic [NB_W-1:0]   nb;
	logic              nb_zero;
	logic              more;
	logic              fin_load;

	// Captured sample word
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       ch_q;
	logic                       fe_q;

	// Handshake
	logic item_acc;
	logic start;
	logic coef_we;

	// Stores
	logic signed [COEF_W-1:0] coef_mem [CDEPTH];
	logic [CDEPTH-1:0]        cvld_q;
	hist_row_t                hist_mem [HDEPTH];
	logic [HDEPTH-1:0]        hvld_q;

	logic [CADDR_W-1:0] coef_waddr;
	logic [CADDR_W-1:0] coef_raddr;
	logic [HADDR_W-1:0] hist_raddr;
	logic [HADDR_W-1:0] hist_waddr;
	logic               coef_re;
	logic               hist_re;
	logic               hist_we;

	logic signed [COEF_W-1:0] coef_q;
	logic                     cvr_q;
	hist_row_t                hist_q;
	logic                     hrv_q;

	// MAC pipe
	ctl_t              ctl0;
	ctl_t              ctl_s1;
	ctl_t              ctl_s2;
	ctl_t              ctl_s3;
	ctl_t              ctl_s4;
	logic [BAND_W-1:0] band_s1;
	logic [BAND_W-1:0] band_s2;
	logic [BAND_W-1:0] band_s3;
	logic [BAND_W-1:0] band_s4;

	hist_row_t                  row;
	logic signed [COEF_W-1:0]   coef_op;
	logic signed [OP_W-1:0]     op;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]           rnd_sum;
	logic signed [RND_W-1:0]    rnd_s4;
	logic signed [YHIST_W-1:0]  y;
	logic signed [SAMPLE_W-1:0] hold_x1_q;
	logic signed [YHIST_W-1:0]  hold_y1_q;
	hist_row_t                  wr_row;
	logic signed [BSUM_W-1:0]   band_sum_q;

	// Final mix
	logic signed [TOT_W-1:0] total;
	logic signed [TOT_W-1:0] half_tot;
	result_t                 res;
	result_t                 out_q;
	logic                    out_valid_q;

	// ---------------------------------------------------------------
	// Handshake and decode of incoming words
	// ---------------------------------------------------------------
	assign item_stall = run_q;
	assign item_acc   = item_valid && !item_stall;

	// Samples on a channel beyond CHANNELS are taken and dropped
	assign start = item_acc && (item.cmd == CMD_SAMPLE) && (int'(item.channel) < CHANNELS);

	assign coef_we = item_acc && (item.cmd == CMD_COEF)
		&& (int'(item.band_index) < BANDS) && (item.coeff_select <= CS_A2);
	assign coef_waddr = CADDR_W'(int'(item.band_index) * COEFS_PER_BAND
		+ int'(item.coeff_select));

	// ---------------------------------------------------------------
	// Microcode fetch and branch conditions
	// ---------------------------------------------------------------
	assign ucw = ucode(pc_q);

	// active_bands above BANDS acts as BANDS
	assign nb = (NB_W'(active_bands_q) > NB_W'(BANDS)) ? NB_W'(BANDS)
		: NB_W'(active_bands_q);
	assign nb_zero = (nb == '0);
	assign more    = (NB_W'(band_q) + NB_W'(1)) < nb;

	always_comb begin
		case (ucw.cond)
			C_NONE:     cond_true = 1'b0;
			C_ALWAYS:   cond_true = 1'b1;
			C_NB_ZERO:  cond_true = nb_zero;
			C_MORE:     cond_true = more;
			C_OUT_BUSY: cond_true = out_valid_q && result_stall;
			default:    cond_true = 1'b0;
		endcase
	end

	// Next step
	always_comb begin
		run_d  = run_q;
		pc_d   = pc_q;
		band_d = band_q;
		if (run_q) begin
			pc_d = cond_true ? ucw.target : upc_t'(pc_q + upc_t'(1));
			if (ucw.clr) begin
				band_d = '0;
			end
			if (ucw.last && cond_true) begin
				band_d = band_q + BAND_W'(1);
			end
			if (ucw.done && !cond_true) begin
				run_d = 1'b0;
			end
		end else if (start) begin
			run_d  = 1'b1;
			pc_d   = U_START;
			band_d = '0;
		end
	end

	// Datapath controls from the current control word
	always_comb begin
		coef_re    = run_q && ucw.coef_rd;
		hist_re    = run_q && ucw.hist_rd;
		fin_load   = run_q && ucw.done && !cond_true;
		ctl0.valid = coef_re;
		ctl0.csel  = ucw.csel;
		ctl0.last  = ucw.last;
	end

	assign coef_raddr = CADDR_W'(int'(band_q) * COEFS_PER_BAND + int'(ucw.csel));
	assign hist_raddr = HADDR_W'(int'(ch_q) * BANDS + int'(band_q));
	assign hist_waddr = HADDR_W'(int'(ch_q) * BANDS + int'(band_s4));

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q          <= 1'b0;
			pc_q           <= U_START;
			band_q         <= '0;
			active_bands_q <= ACT_RESET;
			ctl_s1         <= '0;
			ctl_s2         <= '0;
			ctl_s3         <= '0;
			ctl_s4         <= '0;
			out_valid_q    <= 1'b0;
			cvld_q         <= '0;
			hvld_q         <= '0;
		end else begin
			run_q  <= run_d;
			pc_q   <= pc_d;
			band_q <= band_d;
			if (cfg_we) begin
				active_bands_q <= cfg_wdata;
			end
			ctl_s1 <= ctl0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end
			if (coef_we) begin
				cvld_q[coef_waddr] <= 1'b1;
			end
			if (hist_we) begin
				hvld_q[hist_waddr] <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Coefficient and history stores (registered read, never-written
	// entries masked to zero by their valid bit)
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= item.coeff_value;
		end
		if (coef_re) begin
			coef_q <= coef_mem[coef_raddr];
			cvr_q  <= cvld_q[coef_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= wr_row;
		end
		if (hist_re) begin
			hist_q <= hist_mem[hist_raddr];
			hrv_q  <= hvld_q[hist_raddr];
		end
	end

	// ---------------------------------------------------------------
	// s1: operand select and multiply
	// ---------------------------------------------------------------
	assign row     = hrv_q ? hist_q : '0;
	assign coef_op = cvr_q ? coef_q : '0;

	always_comb begin
		case (ctl_s1.csel)
			CS_B0:   op = OP_W'(x_q);
			CS_B1:   op = OP_W'(row.x1);
			CS_B2:   op = OP_W'(row.x2);
			CS_A1:   op = OP_W'(row.y1);
			CS_A2:   op = OP_W'(row.y2);
			default: op = '0;
		endcase
	end

	assign prod = coef_op * op;

	// s3: round half up; s4: saturate to the history width
	assign rnd_sum = acc_q + RND_HALF;

	always_comb begin
		if (rnd_s4 > Y_HI) begin
			y = Y_HI[YHIST_W-1:0];
		end else if (rnd_s4 < Y_LO) begin
			y = Y_LO[YHIST_W-1:0];
		end else begin
			y = rnd_s4[YHIST_W-1:0];
		end
	end

	assign hist_we   = ctl_s4.valid && ctl_s4.last;
	assign wr_row.x1 = x_q;
	assign wr_row.x2 = hold_x1_q;
	assign wr_row.y1 = y;
	assign wr_row.y2 = hold_y1_q;

	// ---------------------------------------------------------------
	// Final mix: half of (dry plus band sum), rounded half up, saturated
	// ---------------------------------------------------------------
	assign total    = TOT_W'(x_q) + TOT_W'(band_sum_q) + TOT_W'(1);
	assign half_tot = total >>> 1;

	always_comb begin
		res.channel_out   = ch_q;
		res.frame_end_out = fe_q;
		if (half_tot > S_HI) begin
			res.sample_out = S_HI[SAMPLE_W-1:0];
			res.clipped    = 1'b1;
		end else if (half_tot < S_LO) begin
			res.sample_out = S_LO[SAMPLE_W-1:0];
			res.clipped    = 1'b1;
		end else begin
			res.sample_out = half_tot[SAMPLE_W-1:0];
			res.clipped    = 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (start) begin
			x_q  <= item.sample_in;
			ch_q <= item.channel;
			fe_q <= item.frame_end;
		end

		band_s1 <= band_q;
		band_s2 <= band_s1;
		band_s3 <= band_s2;
		band_s4 <= band_s3;

		// s1 -> s2
		prod_s2 <= prod;
		// keep x1/y1 of this band; hist_q moves on to the next band
		if (ctl_s1.valid && ctl_s1.last) begin
			hold_x1_q <= row.x1;
			hold_y1_q <= row.y1;
		end

		// s2: accumulate, feedback terms subtracted
		if (ctl_s2.valid) begin
			case (ctl_s2.csel)
				CS_B0:        acc_q <= ACC_W'(prod_s2);
				CS_B1, CS_B2: acc_q <= acc_q + ACC_W'(prod_s2);
				CS_A1, CS_A2: acc_q <= acc_q - ACC_W'(prod_s2);
				default:      acc_q <= acc_q;
			endcase
		end

		// s3 -> s4
		if (ctl_s3.valid && ctl_s3.last) begin
			rnd_s4 <= rnd_sum[ACC_W-1:COEF_FRAC];
		end

		if (run_q && ucw.clr) begin
			band_sum_q <= '0;
		end else if (hist_we) begin
			band_sum_q <= band_sum_q + BSUM_W'(y);
		end

		if (fin_load) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_pipe_empty_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && pc_q == U_FIN) |->
		!(ctl_s1.valid || ctl_s2.valid || ctl_s3.valid || ctl_s4.valid))
		else $error("MAC pipe not drained at final mix");

	a_band_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl0.valid |-> (NB_W'(band_q) < nb))
		else $error("band issued beyond active band count");

	a_hist_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(hist_we && hist_re) |-> (hist_waddr != hist_raddr))
		else $error("history row read and written in the same cycle");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(run_q && pc_q == U_FIN))
		else $error("result raised outside the final step");

	a_idle_pipe_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |-> !(ctl_s1.valid || ctl_s4.valid))
		else $error("word taken while MAC pipe busy");

endmodule

@@ tb/pbeq_checker.sv @@
// Scoreboard for parallel_biquad_eq_bank: watches the item, result and config ports.
// Depends on pbeq_pkg for word types, widths and codes; its own mirror of the filter state.
module pbeq_checker import pbeq_pkg::*; #(
	parameter int BANDS    = DEF_BANDS,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  item_t            item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  result_t          result,
	input  logic             cfg_we,
	input  logic [ACT_W-1:0] cfg_wdata,
	output int               mismatches,
	output int               open_count
);

	localparam int WIDE = 128;
	localparam logic signed [WIDE-1:0] BAND_HALF = 128'sd1 <<< (COEF_FRAC - 1);
	localparam logic signed [WIDE-1:0] BAND_MAX  = (128'sd1 <<< (YHIST_W - 1)) - 1;
	localparam logic signed [WIDE-1:0] BAND_MIN  = -(128'sd1 <<< (YHIST_W - 1));
	localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint OUT_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

	logic signed [COEF_W-1:0]   coef_mem [BANDS][COEFS_PER_BAND];
	logic signed [SAMPLE_W-1:0] x_hist   [CHANNELS][BANDS][2];
	logic signed [YHIST_W-1:0]  y_hist   [CHANNELS][BANDS][2];
	logic [ACT_W-1:0]           bands_cfg;
	result_t                    due_samples [$];

	// Coefficient write, or one sample through every active band; queues the sample result.
	function automatic void equalize(input item_t w);
		int b;
		int i;
		int nb;
		int ch;
		longint mix;
		logic signed [WIDE-1:0] x;
		logic signed [WIDE-1:0] acc;
		logic signed [WIDE-1:0] k [COEFS_PER_BAND];
		logic signed [YHIST_W-1:0] y;
		result_t r;
		if (w.cmd == CMD_COEF) begin
			if (w.band_index < BANDS && w.coeff_select <= CS_A2)
				coef_mem[w.band_index][w.coeff_select] = w.coeff_value;
			return;
		end
		ch = w.channel;
		if (ch >= CHANNELS)
			return;
		nb = (bands_cfg > BANDS) ? BANDS : bands_cfg;
		x = $signed(w.sample_in);
		mix = $signed(w.sample_in);
		for (b = 0; b < nb; b++) begin
			for (i = 0; i < COEFS_PER_BAND; i++)
				k[i] = coef_mem[b][i];
			// exact DF-I sum, then round half up back to sample scale
			acc = k[CS_B0] * x
				+ k[CS_B1] * x_hist[ch][b][0]
				+ k[CS_B2] * x_hist[ch][b][1]
				- k[CS_A1] * y_hist[ch][b][0]
				- k[CS_A2] * y_hist[ch][b][1];
			acc = (acc + BAND_HALF) >>> COEF_FRAC;
			if (acc > BAND_MAX)
				y = BAND_MAX[YHIST_W-1:0];
			else if (acc < BAND_MIN)
				y = BAND_MIN[YHIST_W-1:0];
			else
				y = acc[YHIST_W-1:0];
			x_hist[ch][b][1] = x_hist[ch][b][0];
			x_hist[ch][b][0] = w.sample_in;
			y_hist[ch][b][1] = y_hist[ch][b][0];
			y_hist[ch][b][0] = y;
			mix += y;
		end
		mix = (mix + 1) >>> 1;
		r.clipped = (mix > OUT_MAX) || (mix < OUT_MIN);
		if (mix > OUT_MAX)
			mix = OUT_MAX;
		else if (mix < OUT_MIN)
			mix = OUT_MIN;
		r.sample_out    = mix[SAMPLE_W-1:0];
		r.channel_out   = w.channel;
		r.frame_end_out = w.frame_end;
		due_samples.push_back(r);
	endfunction

	always @(posedge clk) begin : watch
		result_t want;
		if (!arst_n) begin
			bands_cfg = ACT_RESET;
			foreach (coef_mem[b, c])
				coef_mem[b][c] = '0;
			foreach (x_hist[c, b, t]) begin
				x_hist[c][b][t] = '0;
				y_hist[c][b][t] = '0;
			end
			due_samples.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (due_samples.size() == 0) begin
					mismatches++;
					$display("%0t pbeq_checker: unexpected word, expected none actual %h",
						$time, result);
				end else begin
					want = due_samples.pop_front();
					if (result.sample_out !== want.sample_out) begin
						mismatches++;
						$display("%0t pbeq_checker: sample_out expected %0d actual %0d",
							$time, $signed(want.sample_out), $signed(result.sample_out));
					end
					if (result.channel_out !== want.channel_out) begin
						mismatches++;
						$display("%0t pbeq_checker: channel_out expected %0d actual %0d",
							$time, want.channel_out, result.channel_out);
					end
					if (result.frame_end_out !== want.frame_end_out) begin
						mismatches++;
						$display("%0t pbeq_checker: frame_end_out expected %0d actual %0d",
							$time, want.frame_end_out, result.frame_end_out);
					end
					if (result.clipped !== want.clipped) begin
						mismatches++;
						$display("%0t pbeq_checker: clipped expected %0d actual %0d",
							$time, want.clipped, result.clipped);
					end
				end
			end
			if (cfg_we)
				bands_cfg = cfg_wdata;
			if (item_valid && !item_stall)
				equalize(item);
		end
		open_count <= due_samples.size();
	end

endmodule

@@ tb/tb_top.sv @@
// Top of the parallel_biquad_eq_bank testbench: clock, reset, stimulus, pacing and verdict.
// Depends on pbeq_pkg, the block itself and pbeq_checker, which does all the comparing.
module tb_top import pbeq_pkg::*;;

	// Generous: well above the slowest legal run.
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 116;
	// Covers a full eight-band sample plus a trailing coefficient write.
	localparam int SETTLE      = 60;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0]   C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0]   C_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	item_t            item         = '0;
	logic             result_stall = 1'b0;
	logic             cfg_we       = 1'b0;
	logic [ACT_W-1:0] cfg_wdata    = ACT_RESET;
	logic             item_stall;
	logic             result_valid;
	result_t          result;
	int               mismatches;
	int               open_count;

	// Set for the closing phase: no gaps from the sender, no stalls from the sink.
	bit quiet = 1'b0;
	int sink_run = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	parallel_biquad_eq_bank uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	pbeq_checker eq_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.open_count   (open_count)
	);

	// Sink pacing: random stall bursts between open runs of varying length.
	always @(posedge clk) begin
		if (quiet) begin
			result_stall <= 1'b0;
			sink_run <= 0;
		end else if (sink_run == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				sink_run <= $urandom_range(0, 17);
			end else begin
				result_stall <= 1'b0;
				sink_run <= $urandom_range(1, 60);
			end
		end else begin
			sink_run <= sink_run - 1;
		end
	end

	initial begin : watchdog
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic item_t sample_word(input logic signed [SAMPLE_W-1:0] x,
		input logic ch, input logic fe);
		item_t w;
		w = '0;
		w.cmd       = CMD_SAMPLE;
		w.sample_in = x;
		w.channel   = ch;
		w.frame_end = fe;
		return w;
	endfunction

	function automatic item_t coef_word(input int band, input csel_t sel,
		input logic signed [COEF_W-1:0] v);
		item_t w;
		w = '0;
		w.cmd          = CMD_COEF;
		w.band_index   = BIDX_W'(band);
		w.coeff_select = sel;
		w.coeff_value  = v;
		return w;
	endfunction

	// Present one word, hold it until taken, then maybe leave a gap.
	// Valid stays high across back-to-back words.
	task automatic send_word(input item_t w);
		int gap;
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender holds off until every queued sample word has come back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
	endtask

	// Band count only changes with the pipe empty and the sequencer settled.
	task automatic set_bands(input logic [ACT_W-1:0] nb);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_wdata <= nb;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		item_t w;
		int p;
		int n;
		int b;
		logic [ACT_W-1:0] plan [8];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-zero store gives half dry, on both channels and extremes.
		send_word(sample_word(S_MAX, 1'b0, 1'b0));
		send_word(sample_word(S_MIN, 1'b1, 1'b1));
		// selects above a2 must be dropped
		send_word(coef_word(0, csel_t'(5), C_MAX));
		send_word(coef_word(0, csel_t'(6), C_MAX));
		send_word(coef_word(0, csel_t'(7), C_MAX));
		send_word(sample_word(S_MAX, 1'b0, 1'b0));
		// max b0 on all eight bands: output clips both ways
		for (b = 0; b < DEF_BANDS; b++)
			send_word(coef_word(b, CS_B0, C_MAX));
		send_word(sample_word(S_MAX, 1'b0, 1'b1));
		send_word(sample_word(S_MIN, 1'b1, 1'b0));
		// band 0 turns violently unstable: its own output saturates
		send_word(coef_word(0, CS_B1, C_MIN));
		send_word(coef_word(0, CS_B2, C_MIN));
		send_word(coef_word(0, CS_A1, C_MIN));
		send_word(coef_word(0, CS_A2, C_MAX));
		send_word(sample_word(24'sd1000, 1'b0, 1'b0));
		send_word(sample_word(-24'sd1, 1'b0, 1'b0));
		send_word(sample_word(24'sd0, 1'b1, 1'b0));
		send_word(sample_word(S_MIN, 1'b0, 1'b0));
		send_word(sample_word(S_MAX, 1'b0, 1'b1));

		// Band-count plan: one, full, zero, above range, mixed; last phase runs quiet.
		plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd8};
		plan[6] = ACT_W'($urandom_range(0, 15));
		for (p = 0; p < 8; p++) begin
			if (p == 7)
				quiet = 1'b1;
			set_bands(plan[p]);
			for (n = 0; n < PHASE_WORDS; n++) begin
				w.cmd          = ($urandom_range(0, 4) == 0) ? CMD_COEF : CMD_SAMPLE;
				w.sample_in    = SAMPLE_W'($urandom);
				w.channel      = 1'($urandom);
				w.frame_end    = ($urandom_range(0, 15) == 0);
				w.band_index   = BIDX_W'($urandom);
				w.coeff_select = ($urandom_range(0, 7) == 0) ? csel_t'($urandom_range(5, 7))
					: csel_t'($urandom_range(0, 4));
				w.coeff_value  = $urandom;
				if (w.cmd == CMD_SAMPLE) begin
					if ($urandom_range(0, 9) == 0)
						w.sample_in = $urandom_range(0, 1) ? S_MAX : S_MIN;
					else
						w.sample_in = $signed(w.sample_in) >>> $urandom_range(0, 4);
				end else if ($urandom_range(0, 9) != 0) begin
					// mostly tame filters: |b| <= 1, feedback small enough to stay stable
					if (w.coeff_select >= CS_A1)
						w.coeff_value = $signed(w.coeff_value) >>> $urandom_range(4, 7);
					else
						w.coeff_value = $signed(w.coeff_value) >>> $urandom_range(3, 6);
				end
				send_word(w);
			end
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && open_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ parallel_biquad_eq_bank.f @@
hw/rtl/pbeq_pkg.sv
hw/rtl/parallel_biquad_eq_bank.sv
tb/pbeq_checker.sv
tb/tb_top.sv
